@@ rtl/otsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Otsu threshold binarizer.
// No dependencies; imported by the core and its checker.
package otsu_pkg;

	localparam int MAX_PIXELS_DEF = 4194304;
	localparam int BINS           = 256;
	localparam logic [7:0] PIX_WHITE = 8'hFF;
	localparam logic [7:0] PIX_BLACK = 8'h00;
	localparam logic [7:0] LAST_BIN  = 8'hFF;
	// Tie sum and tie count widths: at most 255 scored bins.
	localparam int SUMW = 16;
	localparam int CNTW = 9;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_RUN,
		ST_DRAIN,
		ST_RD,
		ST_ACC,
		ST_MA,
		ST_MB,
		ST_MD,
		ST_MW,
		ST_ML,
		ST_MR,
		ST_DIV,
		ST_REPORT
	} state_t;

endpackage

@@ rtl/otsu_threshold_binarizer_core.sv @@
`timescale 1ns / 1ps
// Otsu threshold binarizer top level: histogram RAM, threshold sweep, binariser.
// Depends on otsu_pkg and otsu_ram.
//
// After reset the core clears the histogram RAM, one bin per cycle, with the
// input held off. Histogram words (tuser 0) and binarise words (tuser 1) are
// then taken one per cycle while the output slot is free.
// A histogram word with tlast ends the image: the input then stalls while the
// core sweeps the 256 bins of the histogram RAM, clearing each bin as it reads
// it, and scores each threshold that can split the image with one shared
// shift-add multiplier. A scored bin takes six multiplications in turn, each
// stepping one bit of its multiplier operand per cycle up to the highest set
// bit. A shift-subtract divider then averages the tied thresholds, after which
// the report word is issued and input resumes. Bins are updated by
// read-modify-write with forwarding.
module otsu_threshold_binarizer_core #(
	parameter int MAX_PIXELS = otsu_pkg::MAX_PIXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // pixel_in
	input  logic        s_axis_tuser,  // func
	input  logic        s_axis_tlast,  // last_pixel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_pixel, threshold_level
	output logic        m_axis_tuser   // is_report
);
	import otsu_pkg::*;

	localparam int CW   = $clog2(MAX_PIXELS + 1);
	localparam int MW   = CW + 8;
	localparam int AW   = MW + CW;
	localparam int DW   = AW;
	localparam int NUMW = 2 * AW;
	localparam int DENW = 2 * CW;
	localparam int LW   = NUMW + DENW;
	localparam int DCW  = $clog2(SUMW + 1);

	state_t state_q, state_d;

	logic            accept;
	logic            counted;
	logic [CW-1:0]   total_q;
	logic [MW-1:0]   bigm_q;
	logic [7:0]      thr_q;
	logic [7:0]      clr_q;

	logic            s1_v;
	logic [7:0]      s1_addr;
	logic            wr_v_q;
	logic [7:0]      wr_addr_q;
	logic [CW-1:0]   wr_data_q;
	logic [CW-1:0]   inc;

	logic            ram_we;
	logic [7:0]      ram_waddr;
	logic [CW-1:0]   ram_wdata;
	logic [7:0]      ram_raddr;
	logic [CW-1:0]   ram_rdata;

	logic            out_valid_q;
	logic [15:0]     out_data_q;
	logic            out_user_q;
	logic            slot_free;

	logic [7:0]      k_q;
	logic [CW-1:0]   w_q;
	logic [MW-1:0]   m_q;
	logic [CW-1:0]   w_new;
	logic [MW-1:0]   m_new;
	logic            k_valid;

	logic [LW-1:0]   mul_a_q;
	logic [DW-1:0]   mul_b_q;
	logic [LW-1:0]   mul_acc_q;
	logic            mul_done;

	logic [AW-1:0]   prod_a_q;
	logic [AW-1:0]   prod_b;
	logic [DW-1:0]   diff;
	logic [NUMW-1:0] num_q;
	logic [DENW-1:0] den_q;
	logic [LW-1:0]   lhs_q;
	logic [NUMW-1:0] best_num_q;
	logic [DENW-1:0] best_den_q;
	logic [SUMW-1:0] sum_q;
	logic [CNTW-1:0] count_q;

	logic [SUMW-1:0] div_q;
	logic [CNTW-1:0] rem_q;
	logic [DCW-1:0]  dcnt_q;
	logic [CNTW:0]   rem_sh;
	logic            rem_ge;

	assign slot_free = !out_valid_q || m_axis_tready;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign counted   = (total_q < CW'(MAX_PIXELS));

	// Histogram RAM and its read-modify-write path.
	assign inc = ((wr_v_q && (wr_addr_q == s1_addr)) ? wr_data_q : ram_rdata) + CW'(1);

	assign ram_we    = s1_v || (state_q == ST_ACC) || (state_q == ST_CLEAR);
	assign ram_waddr = s1_v ? s1_addr : ((state_q == ST_CLEAR) ? clr_q : k_q);
	assign ram_wdata = s1_v ? inc : '0;
	assign ram_raddr = (state_q == ST_RUN) ? s_axis_tdata : k_q;

	otsu_ram #(
		.WIDTH(CW),
		.DEPTH(BINS)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sweep arithmetic.
	assign w_new   = w_q + ram_rdata;
	assign m_new   = m_q + MW'(k_q) * MW'(ram_rdata);
	assign k_valid = (k_q != LAST_BIN) && (w_new != '0) && (w_new < total_q);
	assign mul_done = (mul_b_q == '0);
	assign prod_b   = AW'(mul_acc_q);
	assign diff     = (prod_a_q >= prod_b) ? (prod_a_q - prod_b) : (prod_b - prod_a_q);

	assign rem_sh = {rem_q, div_q[SUMW-1]};
	assign rem_ge = (rem_sh >= {1'b0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_CLEAR: if (clr_q == LAST_BIN) state_d = ST_RUN;
			ST_RUN: begin
				s_axis_tready = slot_free;
				if (accept && !s_axis_tuser && s_axis_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_RD;
			ST_RD:    state_d = ST_ACC;
			ST_ACC: begin
				if (k_valid) begin
					state_d = ST_MA;
				end else if (k_q == LAST_BIN) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_MA: if (mul_done) state_d = ST_MB;
			ST_MB: if (mul_done) state_d = ST_MD;
			ST_MD: if (mul_done) state_d = ST_MW;
			ST_MW: if (mul_done) state_d = ST_ML;
			ST_ML: if (mul_done) state_d = ST_MR;
			ST_MR: if (mul_done) state_d = ST_RD;
			ST_DIV: begin
				if (dcnt_q == DCW'(SUMW - 1)) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: if (slot_free) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v        <= 1'b0;
			wr_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			bigm_q      <= '0;
			thr_q       <= '0;
			clr_q       <= '0;
		end else begin
			s1_v   <= accept && !s_axis_tuser && counted;
			wr_v_q <= s1_v;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 8'd1;
			end
			if (accept && !s_axis_tuser && counted) begin
				total_q <= total_q + CW'(1);
				bigm_q  <= bigm_q + MW'(s_axis_tdata);
			end
			if ((accept && s_axis_tuser) || (state_q == ST_REPORT && slot_free)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_REPORT && slot_free) begin
				thr_q       <= div_q[7:0];
				total_q     <= '0;
				bigm_q      <= '0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		s1_addr   <= s_axis_tdata;
		wr_addr_q <= s1_addr;
		wr_data_q <= inc;
		if (accept && s_axis_tuser) begin
			out_data_q <= {thr_q, (s_axis_tdata > thr_q) ? PIX_WHITE : PIX_BLACK};
			out_user_q <= 1'b0;
		end
		if (state_q == ST_REPORT && slot_free) begin
			out_data_q <= {div_q[7:0], PIX_BLACK};
			out_user_q <= 1'b1;
		end

		case (state_q)
			ST_DRAIN: begin
				k_q        <= '0;
				w_q        <= '0;
				m_q        <= '0;
				best_num_q <= '0;
				best_den_q <= DENW'(1);
				sum_q      <= '0;
				count_q    <= CNTW'(1);
			end
			ST_ACC: begin
				w_q <= w_new;
				m_q <= m_new;
				if (k_valid) begin
					mul_a_q   <= LW'(bigm_q);
					mul_b_q   <= DW'(w_new);
					mul_acc_q <= '0;
				end else if (k_q == LAST_BIN) begin
					div_q  <= sum_q;
					rem_q  <= '0;
					dcnt_q <= '0;
				end else begin
					k_q <= k_q + 8'd1;
				end
			end
			ST_MA, ST_MB, ST_MD, ST_MW, ST_ML, ST_MR: begin
				if (!mul_done) begin
					if (mul_b_q[0]) begin
						mul_acc_q <= mul_acc_q + mul_a_q;
					end
					mul_a_q <= mul_a_q << 1;
					mul_b_q <= mul_b_q >> 1;
				end else begin
					mul_acc_q <= '0;
					case (state_q)
						ST_MA: begin
							prod_a_q <= prod_b;
							mul_a_q  <= LW'(m_q);
							mul_b_q  <= DW'(total_q);
						end
						ST_MB: begin
							mul_a_q <= LW'(diff);
							mul_b_q <= diff;
						end
						ST_MD: begin
							num_q   <= NUMW'(mul_acc_q);
							mul_a_q <= LW'(w_q);
							mul_b_q <= DW'(total_q - w_q);
						end
						ST_MW: begin
							den_q   <= DENW'(mul_acc_q);
							mul_a_q <= LW'(num_q);
							mul_b_q <= DW'(best_den_q);
						end
						ST_ML: begin
							lhs_q   <= mul_acc_q;
							mul_a_q <= LW'(best_num_q);
							mul_b_q <= DW'(den_q);
						end
						default: begin
							// Compare the two cross products of the score fractions.
							if (lhs_q > mul_acc_q) begin
								best_num_q <= num_q;
								best_den_q <= den_q;
								sum_q      <= SUMW'(k_q);
								count_q    <= CNTW'(1);
							end else if (lhs_q == mul_acc_q) begin
								sum_q   <= sum_q + SUMW'(k_q);
								count_q <= count_q + CNTW'(1);
							end
							k_q <= k_q + 8'd1;
						end
					endcase
				end
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? CNTW'(rem_sh - {1'b0, count_q}) : CNTW'(rem_sh);
				div_q  <= {div_q[SUMW-2:0], rem_ge};
				dcnt_q <= dcnt_q + DCW'(1);
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

@@ rtl/otsu_ram.sv @@
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module otsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/otsu_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the Otsu threshold binarizer, bound to the top level.
// Depends on otsu_pkg and otsu_threshold_binarizer_core.
module otsu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	import otsu_pkg::*;

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// A report word carries a black pixel.
	a_report_px: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == PIX_BLACK)
		else $error("report word with non-zero pixel");

	// A binarised word is black or white.
	a_binary: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			(m_axis_tdata[7:0] == PIX_BLACK || m_axis_tdata[7:0] == PIX_WHITE))
		else $error("binarised pixel neither black nor white");

	// The end of an image stops the input for the sweep.
	a_sweep_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after the last pixel of an image");

endmodule

bind otsu_threshold_binarizer_core otsu_chk u_otsu_chk (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for otsu_threshold_binarizer_core: random images and binarise
// words against an exact integer Otsu predictor. Depends on otsu_pkg and the core.
module tb;
	import otsu_pkg::*;

	// A small pixel limit lets the bench reach the overflow case cheaply.
	localparam int IMG_LIMIT = 48;

	typedef struct packed {
		logic       func;
		logic [7:0] pix;
		logic       last;
	} word_t;

	typedef struct packed {
		logic [7:0] out_pixel;
		logic [7:0] level;
		logic       is_report;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // pixel_in
	logic        s_axis_tuser = 1'b0; // func
	logic        s_axis_tlast = 1'b0; // last_pixel
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // out_pixel, threshold_level
	logic        m_axis_tuser;       // is_report

	word_t   pending_words[$];
	result_t expected_results[$];
	int      fails = 0;

	logic [30:0] hist_model[BINS];
	logic [30:0] total_model;
	logic [7:0]  thr_model;

	otsu_threshold_binarizer_core #(.MAX_PIXELS(IMG_LIMIT)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact between-class variance sweep, ties averaged with a count starting at one.
	function automatic logic [7:0] otsu_pick();
		bit [255:0] n, big_m, w, m, a, b, d, num, den, lhs, rhs, best_num, best_den;
		int sum, count;
		n = total_model;
		big_m = 0;
		w = 0;
		m = 0;
		best_num = 0;
		best_den = 1;
		sum = 0;
		count = 1;
		for (int k = 0; k < BINS; k++)
			big_m += k * hist_model[k];
		for (int k = 0; k < BINS - 1; k++) begin
			w += hist_model[k];
			m += k * hist_model[k];
			if (w == 0 || w >= n)
				continue;
			a = big_m * w;
			b = m * n;
			d = (a >= b) ? a - b : b - a;
			num = d * d;
			den = w * (n - w);
			lhs = num * best_den;
			rhs = best_num * den;
			if (lhs > rhs) begin
				best_num = num;
				best_den = den;
				sum = k;
				count = 1;
			end else if (lhs == rhs) begin
				sum += k;
				count += 1;
			end
		end
		return 8'(sum / count);
	endfunction

	function automatic void predict_word(word_t wd);
		result_t r;
		if (wd.func) begin
			r.out_pixel = (wd.pix > thr_model) ? PIX_WHITE : PIX_BLACK;
			r.level = thr_model;
			r.is_report = 1'b0;
			expected_results.push_back(r);
			return;
		end
		if (total_model < IMG_LIMIT) begin
			hist_model[wd.pix] += 1;
			total_model += 1;
		end
		if (!wd.last)
			return;
		thr_model = otsu_pick();
		foreach (hist_model[i])
			hist_model[i] = '0;
		total_model = '0;
		r.out_pixel = PIX_BLACK;
		r.level = thr_model;
		r.is_report = 1'b1;
		expected_results.push_back(r);
	endfunction

	function automatic void push_word(logic func, logic [7:0] pix, logic last);
		word_t wd;
		wd.func = func;
		wd.pix = pix;
		wd.last = last;
		pending_words.push_back(wd);
	endfunction

	// Image of npix pixels: 0 uniform, 1 two clusters, 2 one level, 3 a few levels.
	function automatic void push_image(int npix, int style);
		int c0, c1, v;
		int levels[4];
		c0 = $urandom_range(0, 255);
		c1 = $urandom_range(0, 255);
		foreach (levels[i])
			levels[i] = $urandom_range(0, 255);
		for (int i = 0; i < npix; i++) begin
			case (style)
				0: v = $urandom_range(0, 255);
				1: begin
					v = (($urandom & 1) ? c0 : c1) + $urandom_range(0, 16) - 8;
					v = (v < 0) ? 0 : (v > 255) ? 255 : v;
				end
				2: v = c0;
				default: v = levels[$urandom_range(0, 3)];
			endcase
			push_word(1'b0, 8'(v), i == npix - 1);
		end
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		word_t wd;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_word('{s_axis_tuser, s_axis_tdata, s_axis_tlast});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					wd = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= wd.func;
					s_axis_tdata <= wd.pix;
					s_axis_tlast <= wd.last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall pattern switches among four modes at random intervals.
	int stall_mode = 0;
	int mode_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser};
				if (expected_results.size() == 0) begin
					$error("unexpected word: out_pixel %0d threshold_level %0d is_report %0d",
						got.out_pixel, got.level, got.is_report);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (got.out_pixel !== want.out_pixel) begin
						$error("out_pixel: expected %0d, actual %0d", want.out_pixel, got.out_pixel);
						fails++;
					end
					if (got.level !== want.level) begin
						$error("threshold_level: expected %0d, actual %0d", want.level, got.level);
						fails++;
					end
					if (got.is_report !== want.is_report) begin
						$error("is_report: expected %0d, actual %0d", want.is_report, got.is_report);
						fails++;
					end
				end
			end
			if (mode_cycles == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_cycles = $urandom_range(50, 400);
			end else begin
				mode_cycles--;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 1) != 0);
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		foreach (hist_model[i])
			hist_model[i] = '0;
		total_model = '0;
		thr_model = '0;

		// Directed: binarise before any image, extremes, single-level and tiny images.
		push_word(1'b1, 8'd0, 1'b0);
		push_word(1'b1, 8'd255, 1'b1);
		push_word(1'b0, 8'd77, 1'b1);
		push_word(1'b0, 8'd0, 1'b0);
		push_word(1'b0, 8'd0, 1'b0);
		push_word(1'b0, 8'd255, 1'b0);
		push_word(1'b0, 8'd255, 1'b1);
		push_word(1'b1, 8'd127, 1'b0);
		push_word(1'b1, 8'd128, 1'b1);
		push_word(1'b1, 8'd0, 1'b0);
		push_word(1'b1, 8'd255, 1'b0);
		push_word(1'b0, 8'd10, 1'b0);
		push_word(1'b0, 8'd20, 1'b0);
		push_word(1'b0, 8'd30, 1'b1);
		push_word(1'b1, 8'd20, 1'b0);
		push_word(1'b1, 8'd21, 1'b0);
		// Overflow: more pixels than the limit, the surplus is not counted.
		push_image(IMG_LIMIT + 10, 1);
		push_word(1'b1, 8'd100, 1'b0);

		while (pending_words.size() < 1750) begin
			push_image($urandom_range(0, 9) == 0 ? $urandom_range(IMG_LIMIT - 4, IMG_LIMIT + 8)
				: $urandom_range(1, 30), $urandom_range(0, 3));
			repeat ($urandom_range(0, 12))
				push_word(1'b1, 8'($urandom), 1'($urandom));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_words.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#300ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/otsu_pkg.sv
rtl/otsu_ram.sv
rtl/otsu_threshold_binarizer_core.sv
rtl/otsu_chk.sv
test/tb.sv
